// ----- rtl/ssat_pkg.sv -----
package ssat_pkg;

  localparam int HIST_DEPTH_DEF  = 8;
  localparam int ANGLE_BITS_DEF  = 32;
  localparam int ZERO_DEG_DEF    = 0;

  localparam int HIST_W          = 24;
  localparam int PERIOD_W        = 25;
  localparam int DIV_W           = 33;

  localparam logic [31:0] INTERVAL_MIN = 32'd10000;
  localparam logic [31:0] INTERVAL_MAX = 32'd10000000;
  localparam logic [31:0] STOP_LIMIT   = 32'd1000000;
  localparam logic [31:0] PERIOD_FLOOR = 32'd10000;
  localparam logic [31:0] RATE_RESET   = 32'd256;
  localparam logic [31:0] PERIOD_RESET = 32'd1 << 26;
  localparam int          NUDGE_SHIFT  = 17;
  localparam int          LIMIT_SHIFT  = 4;

  localparam logic CFG_LOCK_ENABLE = 1'b0;
  localparam logic CFG_ZERO_DRIFT  = 1'b1;

  typedef struct packed {
    logic [31:0] now;
    logic        sync;
    logic        edge_seen;
    logic        in_range;
    logic [31:0] elapsed;
  } ssat_job_t;

endpackage

// ----- rtl/ssat_if.sv -----
interface ssat_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] timestamp_us;
  logic        sync_pin;
  modport source (output valid, timestamp_us, sync_pin, input ready);
  modport sink   (input valid, timestamp_us, sync_pin, output ready);
endinterface

interface ssat_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle;
  logic        stopped;
  logic [24:0] period;
  logic [31:0] raw_period;
  modport source (output valid, angle, stopped, period, raw_period, input ready);
  modport sink   (input valid, angle, stopped, period, raw_period, output ready);
endinterface

interface ssat_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ssat_front.sv -----
module ssat_front
  import ssat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_timestamp_us,
  input  logic        in_sync_pin,
  output logic        q_valid,
  input  logic        q_ready,
  output ssat_job_t   q_job
);
  // front owns edge detection and last edge time; two-entry queue to back
  logic        prev_sync_r, prev_sync_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  ssat_job_t   q_r [2];
  logic [1:0]  cnt_r;
  logic        rd_r, wr_r;
  ssat_job_t   job;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = q_r[rd_r];

  always_comb begin
    job.now       = in_timestamp_us;
    job.sync      = in_sync_pin;
    job.elapsed   = in_timestamp_us - last_edge_r;
    job.edge_seen = in_sync_pin != prev_sync_r;
    job.in_range  = (job.elapsed > INTERVAL_MIN) && (job.elapsed < INTERVAL_MAX);
    prev_sync_nxt = prev_sync_r;
    last_edge_nxt = last_edge_r;
    if (push && job.edge_seen) begin
      prev_sync_nxt = in_sync_pin;
      last_edge_nxt = in_timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= job;
    if (!rst_n) begin
      prev_sync_r <= 1'b1;
      last_edge_r <= '0;
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      prev_sync_r <= prev_sync_nxt;
      last_edge_r <= last_edge_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_edge_time: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.edge_seen |=> last_edge_r == $past(in_timestamp_us))
    else $error("edge time not taken");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("ready when full");
endmodule

// ----- rtl/ssat_back.sv -----
module ssat_back
  import ssat_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int ZERO_DEGREES  = ZERO_DEG_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  ssat_job_t   q_job,
  input  logic        lock_enable,
  input  logic [31:0] zero_drift,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_angle,
  output logic        out_stopped,
  output logic [24:0] out_period,
  output logic [31:0] out_raw_period
);
  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LO_RANK = (HISTORY_DEPTH - 1) / 2;
  localparam int HI_RANK = HISTORY_DEPTH / 2;
  localparam logic [32:0] FULL = 33'd1 << ANGLE_BITS;
  localparam logic [31:0] HALF = 32'(FULL >> 1);
  localparam logic [31:0] TMASK = 32'(FULL - 33'd1);
  localparam logic [31:0] ZRST = 32'((((FULL / 33'd360) * 33'(ZERO_DEGREES))) & 33'(TMASK));

  localparam logic [2:0] S_IDLE = 3'd0, S_RANK = 3'd1, S_DIV = 3'd2,
                         S_LOCK = 3'd3, S_ADV = 3'd4, S_OUT = 3'd5,
                         S_SUM = 3'd6;

  logic [2:0]        st_r;
  ssat_job_t         job_r;
  logic [HIST_W-1:0] hist_r [HISTORY_DEPTH];
  logic [IW-1:0]     hidx_r;
  logic [IW-1:0]     k_r;
  logic [31:0]       lo_r, hi_r;
  logic [31:0]       per_r, rate_r, raw_r, phase_r, zoff_r, last_samp_r;
  logic [32:0]       rem_r;
  logic [32:0]       quo_r;
  logic [5:0]        dcnt_r;
  logic [31:0]       dtick_r;

  logic [CW-1:0] nless, nleq;
  logic [IW-1:0] nidx;
  always_comb begin
    nless = '0;
    nleq  = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_r[i] < hist_r[k_r]) nless = nless + CW'(1);
      if (hist_r[i] <= hist_r[k_r]) nleq = nleq + CW'(1);
    end
    nidx = (hidx_r == IW'(HISTORY_DEPTH - 1)) ? '0 : hidx_r + IW'(1);
  end

  logic [32:0] sum33;
  logic [31:0] psum;
  logic [33:0] trial;
  assign sum33 = {1'b0, lo_r} + {1'b0, hi_r};
  assign psum  = (sum33[31:0] < PERIOD_FLOOR) ? PERIOD_FLOOR : sum33[31:0];
  assign trial = {rem_r, quo_r[32]} - {2'b0, per_r};

  logic [31:0] amod;
  logic signed [33:0] off, nud, lim, rr;
  always_comb begin
    amod = (phase_r + (job_r.sync ? 32'd0 : HALF)) & TMASK;
    off  = $signed({2'b0, amod}) - $signed({2'b0, HALF});
    nud  = off >>> NUDGE_SHIFT;
    lim  = $signed({{2{rate_r[31]}}, rate_r});
    lim  = (lim < 0) ? -((-lim) >>> LIMIT_SHIFT) : (lim >>> LIMIT_SHIFT);
    rr   = nud;
    if (rr < -lim) rr = -lim;
    if (rr > lim) rr = lim;
  end

  assign q_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= '0;
      hidx_r <= '0;
      per_r <= PERIOD_RESET;
      rate_r <= RATE_RESET;
      raw_r <= '0;
      phase_r <= '0;
      zoff_r <= ZRST;
      last_samp_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          job_r <= q_job;
          dtick_r <= q_job.now - last_samp_r;
          last_samp_r <= q_job.now;
          if (q_job.edge_seen) raw_r <= {q_job.elapsed[30:0], 1'b0};
          if (q_job.edge_seen && q_job.in_range) begin
            hidx_r <= nidx;
            hist_r[nidx] <= q_job.elapsed[HIST_W-1:0];
            k_r <= '0;
            st_r <= S_RANK;
          end else begin
            st_r <= S_ADV;
          end
        end
        S_RANK: begin
          if (nless <= CW'(LO_RANK) && nleq > CW'(LO_RANK))
            lo_r <= 32'(hist_r[k_r]);
          if (nless <= CW'(HI_RANK) && nleq > CW'(HI_RANK))
            hi_r <= 32'(hist_r[k_r]);
          if (k_r == IW'(HISTORY_DEPTH - 1)) st_r <= S_SUM;
          k_r <= k_r + IW'(1);
        end
        S_SUM: begin
          per_r <= psum;
          rem_r <= '0;
          quo_r <= FULL;
          dcnt_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (!trial[33]) begin
            rem_r <= trial[32:0];
            quo_r <= {quo_r[31:0], 1'b1};
          end else begin
            rem_r <= {rem_r[31:0], quo_r[32]};
            quo_r <= {quo_r[31:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd32) st_r <= lock_enable ? S_LOCK : S_ADV;
          if (dcnt_r == 6'd32)
            rate_r <= !trial[33] ? {quo_r[30:0], 1'b1} : {quo_r[30:0], 1'b0};
        end
        S_LOCK: begin
          rate_r <= rate_r - rr[31:0];
          st_r <= S_ADV;
        end
        S_ADV: begin
          phase_r <= (phase_r + dtick_r * rate_r) & TMASK;
          zoff_r <= (zoff_r + dtick_r * zero_drift) & TMASK;
          st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_angle      = (phase_r + zoff_r) & TMASK;
  assign out_stopped    = job_r.elapsed > STOP_LIMIT;
  assign out_period     = per_r[PERIOD_W-1:0];
  assign out_raw_period = raw_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hidx_r) < 32'(HISTORY_DEPTH)) else $error("bad ring index");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_ready && out_valid)) else $error("overlap");
endmodule

// ----- rtl/spin_sync_angle_tracker.sv -----
// Spin sync angle tracker. Each sample item yields one result item. A sample
// without an in-range sync edge goes straight to the phase advance; one with
// an in-range edge first runs the rank scan of the history ring (one entry a
// cycle), the 33-step restoring divider (one quotient bit a cycle) and, with
// lock enabled, the lock step. A two-item queue lets samples be taken while
// the back end is busy. Write config only while idle.
module spin_sync_angle_tracker
  import ssat_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int ZERO_DEGREES  = ZERO_DEG_DEF
) (
  input logic clk,
  input logic rst_n,
  ssat_in_if.sink   in_ch,
  ssat_out_if.source out_ch,
  ssat_cfg_if.sink  cfg_ch
);
  logic        lock_r;
  logic [31:0] drift_r;
  logic        q_valid, q_ready;
  ssat_job_t   q_job;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b1;
      drift_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LOCK_ENABLE: lock_r <= cfg_ch.data[0];
        CFG_ZERO_DRIFT:  drift_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  ssat_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_timestamp_us(in_ch.timestamp_us), .in_sync_pin(in_ch.sync_pin),
    .q_valid, .q_ready, .q_job
  );

  ssat_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH), .ANGLE_BITS(ANGLE_BITS), .ZERO_DEGREES(ZERO_DEGREES)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .lock_enable(lock_r), .zero_drift(drift_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_angle(out_ch.angle), .out_stopped(out_ch.stopped),
    .out_period(out_ch.period), .out_raw_period(out_ch.raw_period)
  );
endmodule

// ----- test/tb_spin_sync_angle_tracker.sv -----
module tb_spin_sync_angle_tracker;
  import ssat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] ts;
    logic        lvl;
  } sample_t;

  typedef struct {
    logic [31:0] angle;
    logic        stopped;
    logic [24:0] period;
    logic [31:0] raw;
  } track_t;

  localparam int SETTLE = 60;
  localparam int LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ssat_in_if  in_ch();
  ssat_out_if out_ch();
  ssat_cfg_if cfg_ch();

  spin_sync_angle_tracker dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker model state
  logic        m_lock;
  logic [31:0] m_drift;
  logic [31:0] m_hist [8];
  int          m_idx;
  logic [31:0] m_last_edge, m_last_sample, m_phase, m_zero, m_rate, m_fper, m_raw;
  logic        m_prev;

  sample_t pend_q[$];
  track_t  exp_q[$];
  sample_t cur;
  int      errors = 0;
  int      n_results = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      long_hold = 0;
  bit      long_done = 0;
  longint  cycles = 0;

  function automatic logic [31:0] median_pair();
    logic [31:0] s [8];
    logic [31:0] v;
    int j;
    for (int i = 0; i < 8; i++) begin
      v = m_hist[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[3] + s[4];
  endfunction

  function automatic track_t track_sample(sample_t smp);
    track_t r;
    logic [31:0] el, p, m, dt;
    longint t, nudge, lim;
    el = smp.ts - m_last_edge;
    if (smp.lvl != m_prev) begin
      m_prev = smp.lvl;
      m_last_edge = smp.ts;
      m_raw = el * 2;
      if (el > INTERVAL_MIN && el < INTERVAL_MAX) begin
        m_idx = (m_idx + 1) % 8;
        m_hist[m_idx] = {8'd0, el[23:0]};
        p = median_pair();
        if (p < PERIOD_FLOOR) p = PERIOD_FLOOR;
        m_fper = p;
        m_rate = 32'((64'd1 << 32) / p);
        if (m_lock) begin
          m = m_phase + (smp.lvl ? 32'd0 : 32'h8000_0000);
          t = longint'({32'd0, m}) - 64'sh8000_0000;
          nudge = t >>> NUDGE_SHIFT;
          lim = longint'({32'd0, m_rate >> LIMIT_SHIFT});
          if (nudge < -lim) nudge = -lim;
          if (nudge > lim) nudge = lim;
          m_rate = m_rate - nudge[31:0];
        end
      end
    end
    dt = smp.ts - m_last_sample;
    m_last_sample = smp.ts;
    m_phase = m_phase + dt * m_rate;
    m_zero = m_zero + dt * m_drift;
    r.angle = m_phase + m_zero;
    r.stopped = el > STOP_LIMIT;
    r.period = m_fper[24:0];
    r.raw = m_raw;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) exp_q.push_back(track_sample(cur));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_ch.timestamp_us <= cur.ts;
          in_ch.sync_pin <= cur.lvl;
          in_ch.valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    track_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (exp_q.size() == 0) begin
          $error("unexpected result item, angle %h", out_ch.angle);
          errors++;
        end else begin
          e = exp_q.pop_front();
          if (out_ch.angle !== e.angle) begin
            $error("angle exp %h got %h", e.angle, out_ch.angle);
            errors++;
          end
          if (out_ch.stopped !== e.stopped) begin
            $error("stopped exp %b got %b", e.stopped, out_ch.stopped);
            errors++;
          end
          if (out_ch.period !== e.period) begin
            $error("period exp %0d got %0d", e.period, out_ch.period);
            errors++;
          end
          if (out_ch.raw_period !== e.raw) begin
            $error("raw_period exp %h got %h", e.raw, out_ch.raw_period);
            errors++;
          end
        end
      end
      if (!long_done && n_results == 400) begin
        long_done = 1;
        long_hold = 400;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  logic [31:0] g_time;
  logic        g_lvl;
  int          n_items = 0;

  task automatic add(logic [31:0] ts, logic lvl);
    sample_t s;
    s.ts = ts;
    s.lvl = lvl;
    pend_q.push_back(s);
    g_time = ts;
    g_lvl = lvl;
    n_items++;
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || exp_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_LOCK_ENABLE) m_lock = data[0];
    else m_drift = data;
    cfg_ch.valid <= 1'b0;
  endtask

  // several half-turns, polled a few times each
  task automatic spin(int halves, int half);
    int e, k;
    for (int h = 0; h < halves; h++) begin
      e = half + $urandom_range(0, half / 8 + 1) - half / 16;
      k = $urandom_range(1, 5);
      for (int i = 1; i < k; i++) add(g_time + e / k * i - e / k * (i - 1) + 0, g_lvl);
      add(g_time + e - (e / k) * (k - 1), !g_lvl);
    end
  endtask

  initial begin
    int half, mode;
    in_ch.valid = 1'b0;
    in_ch.timestamp_us = '0;
    in_ch.sync_pin = 1'b1;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_LOCK_ENABLE;
    cfg_ch.data = '0;
    m_lock = 1'b1;
    m_drift = '0;
    foreach (m_hist[i]) m_hist[i] = '0;
    m_idx = 0;
    m_last_edge = '0;
    m_last_sample = '0;
    m_prev = 1'b1;
    m_phase = '0;
    m_zero = 32'(((64'd1 << 32) / 360) * ZERO_DEG_DEF);
    m_rate = RATE_RESET;
    m_fper = PERIOD_RESET;
    m_raw = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edge interval boundaries, stop detect, timestamp wrap
    add(32'd0, 1'b1);
    add(32'd5, 1'b1);
    add(32'd100, 1'b0);
    add(32'd10100, 1'b1);
    add(32'd20101, 1'b0);
    add(32'd20101 + 32'd9999999, 1'b1);
    add(g_time + 32'd10000000, 1'b0);
    add(g_time + 32'd1000000, 1'b0);
    add(g_time + 32'd1, 1'b0);
    add(32'hFFFF_FF00, 1'b1);
    add(32'hFFFF_FFFF, 1'b1);
    add(32'h0000_4000, 1'b0);
    spin(6, 20000);
    wait_idle();
    cfg_write(CFG_LOCK_ENABLE, 32'd0);
    cfg_write(CFG_ZERO_DRIFT, 32'h7FFF_FFFF);
    spin(4, 30000);
    add(g_time + 32'd5000, g_lvl);
    wait_idle();
    cfg_write(CFG_LOCK_ENABLE, 32'd1);
    cfg_write(CFG_ZERO_DRIFT, 32'h8000_0000);

    while (n_items < 1300) begin
      mode = $urandom_range(0, 99);
      if (mode < 80) begin
        case ($urandom_range(0, 5))
          0: half = $urandom_range(10001, 11000);
          1: half = $urandom_range(9000000, 9999999);
          2: half = $urandom_range(1000000, 3000000);
          default: half = $urandom_range(10001, 600000);
        endcase
        spin($urandom_range(3, 16), half);
      end else begin
        repeat ($urandom_range(1, 4)) add($urandom, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) < 8) begin
        wait_idle();
        cfg_write(CFG_LOCK_ENABLE, 32'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
          0: cfg_write(CFG_ZERO_DRIFT, 32'd0);
          1: cfg_write(CFG_ZERO_DRIFT, 32'hFFFF_FFFF);
          default: cfg_write(CFG_ZERO_DRIFT, $urandom);
        endcase
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
